/* design/lkv_pkg.sv */
// lkv_pkg: shared types and constants for the lru key-value cache
// holds the request and response payload structs and the operation codes
// no dependencies
`timescale 1ns / 1ps

package lkv_pkg;

  // operation codes carried in the kind field
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // width of the capacity register
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // value returned by a get that misses
  localparam logic signed [31:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } lkv_req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } lkv_rsp_t;

endpackage

/* design/lkv_if.sv */
// lkv_if: valid/ready channel interfaces for the lru key-value cache
// request, response and capacity write channels; depends on lkv_pkg
`timescale 1ns / 1ps

interface lkv_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lkv_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] read_value;
  logic               evicted;
  logic signed [31:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lkv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lkv_pkg::CAP_W-1:0]     capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

/* design/lkv_slot_table.sv */
// lkv_slot_table: fully associative slot table with recency ranks
// parallel key compare, lookup, fill, eviction and rank update; depends on lkv_pkg
`timescale 1ns / 1ps

module lkv_slot_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          exec,
  input  lkv_pkg::lkv_req_t             req,
  input  logic [lkv_pkg::CAP_W-1:0]     capacity,
  output lkv_pkg::lkv_rsp_t             rsp
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = (OW > lkv_pkg::CAP_W) ? OW : lkv_pkg::CAP_W;

  logic signed [31:0]   key_r   [MAX_ENTRIES];
  logic signed [31:0]   data_r  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [IW-1:0]        age_r   [MAX_ENTRIES];
  logic [OW-1:0]        occ_r;

  logic [MAX_ENTRIES-1:0] valid_nxt;
  logic [IW-1:0]        age_nxt [MAX_ENTRIES];
  logic [OW-1:0]        occ_nxt;

  logic          found;
  logic [IW-1:0] found_idx;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] victim_idx;
  logic [IW-1:0] oldest_age;
  logic [CW-1:0] cap_ext;
  logic [CW-1:0] cap_sat;
  logic          room;

  logic          touch_en;
  logic [IW-1:0] touch_idx;
  logic [IW-1:0] touch_age;
  logic          fill_en;
  logic          wr_en;
  logic          wr_key_en;
  logic [IW-1:0] wr_idx;

  // priority encoders: lowest matching, lowest free, oldest valid
  always_comb begin
    found      = 1'b0;
    found_idx  = '0;
    free_idx   = '0;
    victim_idx = '0;
    oldest_age = IW'(occ_r - OW'(1));
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == req.key) begin
        found     = 1'b1;
        found_idx = IW'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
      if (valid_r[i] && age_r[i] == oldest_age) begin
        victim_idx = IW'(i);
      end
    end
  end

  // effective capacity clamped to one .. MAX_ENTRIES
  always_comb begin
    cap_ext = CW'(capacity);
    if (cap_ext == '0) begin
      cap_sat = CW'(1);
    end else if (cap_ext > CW'(MAX_ENTRIES)) begin
      cap_sat = CW'(MAX_ENTRIES);
    end else begin
      cap_sat = cap_ext;
    end
    room = CW'(occ_r) < cap_sat;
  end

  // operation decode and response
  always_comb begin
    rsp       = '0;
    touch_en  = 1'b0;
    touch_idx = '0;
    fill_en   = 1'b0;
    wr_en     = 1'b0;
    wr_key_en = 1'b0;
    wr_idx    = '0;
    if (req.kind == lkv_pkg::KIND_GET) begin
      if (found) begin
        rsp.hit        = 1'b1;
        rsp.read_value = data_r[found_idx];
        touch_en       = 1'b1;
        touch_idx      = found_idx;
      end else begin
        rsp.read_value = lkv_pkg::MISS_VALUE;
      end
    end else if (found) begin
      rsp.hit   = 1'b1;
      wr_en     = 1'b1;
      wr_idx    = found_idx;
      touch_en  = 1'b1;
      touch_idx = found_idx;
    end else if (room) begin
      fill_en   = 1'b1;
      wr_en     = 1'b1;
      wr_key_en = 1'b1;
      wr_idx    = free_idx;
    end else begin
      rsp.evicted     = 1'b1;
      rsp.evicted_key = key_r[victim_idx];
      wr_en           = 1'b1;
      wr_key_en       = 1'b1;
      wr_idx          = victim_idx;
      touch_en        = 1'b1;
      touch_idx       = victim_idx;
    end
  end

  // recency rank update
  always_comb begin
    touch_age = age_r[touch_idx];
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      age_nxt[i] = age_r[i];
      if (fill_en) begin
        if (IW'(i) == free_idx) begin
          age_nxt[i]   = '0;
          valid_nxt[i] = 1'b1;
        end else if (valid_r[i]) begin
          age_nxt[i] = age_r[i] + IW'(1);
        end
      end else if (touch_en) begin
        if (IW'(i) == touch_idx) begin
          age_nxt[i] = '0;
        end else if (valid_r[i] && age_r[i] < touch_age) begin
          age_nxt[i] = age_r[i] + IW'(1);
        end
      end
    end
    if (fill_en) begin
      occ_nxt = occ_r + OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else if (exec) begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  // key and data storage, no reset
  always_ff @(posedge clk) begin
    if (exec && wr_en) begin
      data_r[wr_idx] <= req.value;
      if (wr_key_en) begin
        key_r[wr_idx] <= req.key;
      end
    end
  end

endmodule

/* design/lru_key_value_cache.sv */
// lru_key_value_cache: top level of the lru key-value cache
// input register, slot table and result register; depends on lkv_pkg, lkv_if and lkv_slot_table
`timescale 1ns / 1ps

// usage
//   in_chan: get (kind 0) or put (kind 1) transactions with key and value
//   out_chan: exactly one result transaction per request, in request order,
//     carrying hit, read_value, evicted and evicted_key
//   cfg_chan: writes the 5-bit capacity register; always ready, write only
//     while no request is outstanding
// timing
//   a request waits in the input register while the slot table compares
//   every stored key in parallel, picks the hit, free or oldest slot and
//   updates the recency ranks; the result is registered at the same edge as
//   the rank update, when the request advances; an accepted request is held in
//   the input register, and its result is held in the result register until out_chan takes it
//   throughput: one transaction per cycle while out_chan accepts results, as the
//   slot table compares and updates the ranks combinationally
// reset
//   synchronous active-low rst_n clears all valid flags, ranks, occupancy
//   and the valid bits of both pipeline registers; capacity returns to 16
// backpressure
//   a held result does not block the input register while out_chan is free;
//   when out_chan stalls with both registers full, in_chan.ready drops

module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  lkv_in_if.sink         in_chan,
  lkv_out_if.source      out_chan,
  lkv_cfg_if.sink        cfg_chan
);

  logic                          s1_vld_r;
  lkv_pkg::lkv_req_t             s1_req_r;
  logic                          out_vld_r;
  lkv_pkg::lkv_rsp_t             out_rsp_r;
  logic [lkv_pkg::CAP_W-1:0]     cap_r;

  lkv_pkg::lkv_rsp_t             rsp;
  logic                          advance;
  logic                          in_take;

  // request moves into the result register when there is room for it
  assign advance = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign in_take = in_chan.valid && in_chan.ready;

  assign in_chan.ready  = !s1_vld_r || advance;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid       = out_vld_r;
  assign out_chan.hit         = out_rsp_r.hit;
  assign out_chan.read_value  = out_rsp_r.read_value;
  assign out_chan.evicted     = out_rsp_r.evicted;
  assign out_chan.evicted_key = out_rsp_r.evicted_key;

  lkv_slot_table #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .exec     (advance),
    .req      (s1_req_r),
    .capacity (cap_r),
    .rsp      (rsp)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cap_r     <= lkv_pkg::CAP_RESET;
    end else begin
      if (in_take) begin
        s1_vld_r <= 1'b1;
      end else if (advance) begin
        s1_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_chan.valid) begin
        cap_r <= cfg_chan.capacity;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r.kind  <= in_chan.kind;
      s1_req_r.key   <= in_chan.key;
      s1_req_r.value <= in_chan.value;
    end
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

endmodule

/* verif/tb_lru_key_value_cache.sv */
// tb_lru_key_value_cache: self-checking testbench for the lru key-value cache
// drives get/put transactions, predicts each response with a shadow lru table
// depends on lkv_pkg, lkv_if and lru_key_value_cache
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

  localparam int TABLE_DEPTH = 16;   // matches the block's MAX_ENTRIES
  localparam int STALL_LIMIT = 2000; // cycles with no transaction on any channel
  localparam int ITEMS_PER_PHASE = 80;
  localparam int PHASES = 8;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  lkv_in_if  in_chan();
  lkv_out_if out_chan();
  lkv_cfg_if cfg_chan();

  lru_key_value_cache #(.MAX_ENTRIES(TABLE_DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // shadow copy of the cache table, updated once per accepted request
  bit [31:0]        shadow_key  [TABLE_DEPTH];
  bit [31:0]        shadow_data [TABLE_DEPTH];
  bit               shadow_valid[TABLE_DEPTH];
  int unsigned      shadow_rank [TABLE_DEPTH]; // 0 is most recently used
  int unsigned      shadow_fill;
  logic [lkv_pkg::CAP_W-1:0] shadow_cap;

  lkv_pkg::lkv_req_t req_backlog[$];   // requests waiting to be offered on in_chan
  lkv_pkg::lkv_rsp_t cache_answers[$]; // predicted responses, oldest first
  bit [31:0] key_pool[$];     // keys reused so that hits and evictions happen

  // capacity per random phase; zero and values above the table depth included
  logic [lkv_pkg::CAP_W-1:0] cap_plan[PHASES] =
    '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd3, 5'd17, 5'd8};

  // pacing knobs, changed only at a falling edge by the main sequence
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          burst_req      = 1'b0;

  int unsigned err_count = 0;

  // one line per mismatch, printing capped so a broken block cannot flood the log
  task automatic flag_error(input string what);
    if (err_count < 100) $display("[%0t] lkv check: %s", $realtime, what);
    err_count++;
  endtask

  // zero behaves as one, anything beyond the table depth saturates
  function automatic int unsigned eff_capacity(input logic [lkv_pkg::CAP_W-1:0] c);
    if (c == 0) return 1;
    if (c > TABLE_DEPTH) return TABLE_DEPTH;
    return c;
  endfunction

  // move slot s to the front: every valid slot that was more recent ages by one
  function automatic void promote(input int s);
    int unsigned old_rank;
    old_rank = shadow_rank[s];
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (shadow_valid[i] && i != s && shadow_rank[i] < old_rank) shadow_rank[i]++;
    shadow_rank[s] = 0;
  endfunction

  // apply one get or put to the shadow table and return the response it gives
  function automatic lkv_pkg::lkv_rsp_t cache_access(input lkv_pkg::lkv_req_t r);
    lkv_pkg::lkv_rsp_t rsp;
    int hit_slot;
    int free_slot;
    int victim;
    rsp = '0;
    hit_slot = -1;
    free_slot = -1;
    victim = -1;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (shadow_valid[i] && shadow_key[i] == r.key && hit_slot < 0) hit_slot = i;

    if (r.kind == lkv_pkg::KIND_GET) begin
      if (hit_slot >= 0) begin
        rsp.hit = 1'b1;
        rsp.read_value = shadow_data[hit_slot];
        promote(hit_slot);
      end else begin
        rsp.read_value = lkv_pkg::MISS_VALUE;
      end
    end else if (hit_slot >= 0) begin
      // put hit: overwrite in place
      rsp.hit = 1'b1;
      shadow_data[hit_slot] = r.value;
      promote(hit_slot);
    end else if (shadow_fill < eff_capacity(shadow_cap)) begin
      // put miss with room: lowest free slot, everyone else ages
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (!shadow_valid[i] && free_slot < 0) free_slot = i;
      if (free_slot >= 0) begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (shadow_valid[i]) shadow_rank[i]++;
        shadow_valid[free_slot] = 1'b1;
        shadow_key[free_slot]   = r.key;
        shadow_data[free_slot]  = r.value;
        shadow_rank[free_slot]  = 0;
        shadow_fill++;
      end
    end else begin
      // put miss at or over capacity: replace the least recently used entry
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
          victim = i;
      if (victim >= 0) begin
        rsp.evicted = 1'b1;
        rsp.evicted_key = shadow_key[victim];
        shadow_key[victim]  = r.key;
        shadow_data[victim] = r.value;
        promote(victim);
      end
    end
    return rsp;
  endfunction

  // request driver: offers the next queued transaction once the slot is free,
  // skipping cycles at random to create sender gaps
  always @(posedge clk) begin
    lkv_pkg::lkv_req_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_backlog.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.kind  <= nxt.kind;
        in_chan.key   <= nxt.key;
        in_chan.value <= nxt.value;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // monitor: checks each response against the oldest prediction, then predicts
  // for a request accepted at this edge
  always @(posedge clk) begin
    lkv_pkg::lkv_rsp_t want;
    lkv_pkg::lkv_req_t seen;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (cache_answers.size() == 0) begin
          flag_error("response transaction with no request outstanding");
        end else begin
          want = cache_answers.pop_front();
          if (out_chan.hit !== want.hit)
            flag_error($sformatf("hit got %b want %b", out_chan.hit, want.hit));
          if (out_chan.read_value !== want.read_value)
            flag_error($sformatf("read_value got %h want %h",
                                 out_chan.read_value, want.read_value));
          if (out_chan.evicted !== want.evicted)
            flag_error($sformatf("evicted got %b want %b", out_chan.evicted, want.evicted));
          if (out_chan.evicted_key !== want.evicted_key)
            flag_error($sformatf("evicted_key got %h want %h",
                                 out_chan.evicted_key, want.evicted_key));
        end
      end

      if (in_chan.valid && in_chan.ready) begin
        seen.kind  = in_chan.kind;
        seen.key   = in_chan.key;
        seen.value = in_chan.value;
        cache_answers.push_back(cache_access(seen));
      end
    end
  end

  // receiver pacing: random stalls, plus one long hold-off while the driver keeps pushing fills
  // the pipeline and must drop in_chan.ready
  int unsigned hold_left  = 0;
  bit          burst_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (burst_req && !burst_done) begin
      out_chan.ready <= 1'b0;
      hold_left <= 80;
      burst_done <= 1'b1;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: gives up when no channel completes a transaction for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic queue_request(input logic kind, input bit [31:0] k, input bit [31:0] v);
    lkv_pkg::lkv_req_t r;
    r.kind  = kind;
    r.key   = k;
    r.value = v;
    req_backlog.push_back(r);
  endtask

  // sender pause: returns at a falling edge once every response is back
  // and the block has had time to settle
  task automatic drain();
    while (req_backlog.size() > 0 || in_chan.valid || cache_answers.size() > 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // capacity write, only issued while the block is idle
  task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] c);
    @(posedge clk);
    cfg_chan.valid    <= 1'b1;
    cfg_chan.capacity <= c;
    do @(posedge clk); while (!cfg_chan.ready);
    shadow_cap = c;
    cfg_chan.valid <= 1'b0;
    @(negedge clk);
  endtask

  // main sequence: directed corners first, then paced random phases
  initial begin
    int unsigned pool_size;
    int unsigned mode;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.kind = lkv_pkg::KIND_GET;
    in_chan.key = '0;
    in_chan.value = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.capacity = '0;
    shadow_fill = 0;
    shadow_cap = lkv_pkg::CAP_RESET;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full capacity: miss on empty table, extreme keys and values,
    // get hit, put hit overwrite, plain miss
    write_capacity(5'd16);
    queue_request(lkv_pkg::KIND_GET, 32'h0000_0000, 32'h1111_1111);
    queue_request(lkv_pkg::KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
    queue_request(lkv_pkg::KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
    queue_request(lkv_pkg::KIND_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_request(lkv_pkg::KIND_PUT, 32'hffff_ffff, 32'hffff_ffff);
    queue_request(lkv_pkg::KIND_GET, 32'h8000_0000, 32'h0000_0000);
    queue_request(lkv_pkg::KIND_PUT, 32'h7fff_ffff, 32'h1234_5678);
    queue_request(lkv_pkg::KIND_GET, 32'h7fff_ffff, 32'hffff_ffff);
    queue_request(lkv_pkg::KIND_GET, 32'h0000_0001, 32'h0000_0000);
    drain();

    // capacity dropped below the four live entries: each put miss evicts
    // and the entry count stays put
    write_capacity(5'd2);
    queue_request(lkv_pkg::KIND_PUT, 32'h0000_00aa, 32'h0000_0001);
    queue_request(lkv_pkg::KIND_PUT, 32'h5555_5555, 32'haaaa_aaaa);
    queue_request(lkv_pkg::KIND_GET, 32'h0000_0000, 32'h0000_0000);
    queue_request(lkv_pkg::KIND_GET, 32'h0000_00aa, 32'h0000_0000);
    drain();

    // capacity zero acts as one
    write_capacity(5'd0);
    queue_request(lkv_pkg::KIND_PUT, 32'haaaa_aaaa, 32'h5555_5555);
    queue_request(lkv_pkg::KIND_PUT, 32'haaaa_aaaa, 32'h0000_0007);
    queue_request(lkv_pkg::KIND_GET, 32'h8000_0000, 32'h0000_0000);
    drain();

    // capacity above the table depth saturates
    write_capacity(5'd31);
    queue_request(lkv_pkg::KIND_PUT, 32'h0000_0101, 32'h0f0f_0f0f);
    queue_request(lkv_pkg::KIND_PUT, 32'h0000_0202, 32'hf0f0_f0f0);
    queue_request(lkv_pkg::KIND_PUT, 32'h0000_0303, 32'h0000_0003);
    queue_request(lkv_pkg::KIND_GET, 32'h0000_0202, 32'h0000_0000);
    drain();

    // random phases: a key pool a little larger than the capacity keeps hits,
    // fills and evictions all frequent; a tenth of the keys are fresh noise
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(cap_plan[ph]);
      mode = ph / 2;
      send_idle_pct  = (mode == 1) ? 72 : (mode == 3) ? 20 : 0;
      recv_stall_pct = (mode == 2) ? 72 : (mode == 3) ? 20 : 0;
      burst_req      = (ph == 0);

      pool_size = eff_capacity(cap_plan[ph]) + $urandom_range(1, 4);
      if (key_pool.size() > 0) key_pool.delete($urandom_range(key_pool.size() - 1));
      while (key_pool.size() < pool_size) key_pool.push_back($urandom);
      while (key_pool.size() > pool_size) key_pool.delete($urandom_range(key_pool.size() - 1));

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(9) == 0)
          queue_request($urandom_range(1) ? lkv_pkg::KIND_PUT : lkv_pkg::KIND_GET,
                        $urandom, $urandom);
        else
          queue_request($urandom_range(1) ? lkv_pkg::KIND_PUT : lkv_pkg::KIND_GET,
                        key_pool[$urandom_range(key_pool.size() - 1)], $urandom);
      end
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) @(negedge clk);

    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
